### sv/otqd_pkg.sv
`default_nettype none

package otqd_pkg;

    // Default sizes of the block
    localparam int FIFO_DEPTH_DEF = 16;
    localparam int LEVELS_DEF     = 8;
    localparam int DATA_WIDTH_DEF = 32;

    // Depth of the command queue between front and back
    localparam int CQ_DEPTH = 2;

    // Fixed field widths
    localparam int CMD_W     = 2;
    localparam int MSG_W     = 32;
    localparam int QLEN_W    = 5;
    localparam int TOTAL_W   = 32;
    localparam int LIMIT_W   = 16;
    localparam int FRAC_BITS = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Register reset values: base 150, decay 2.0 in 8.8
    localparam logic [LIMIT_W-1:0] BASE_RST  = 16'd150;
    localparam logic [LIMIT_W-1:0] DECAY_RST = 16'd512;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 2'd2;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        OP_ENQ   = 2'd0,
        OP_POLL  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    // Classified command travelling through the command queue
    typedef struct packed {
        t_op  op;
        logic expecting;
    } t_cmd_ctl;

endpackage

`default_nettype wire

### sv/otqd_front.sv
`default_nettype none

module otqd_front #(
    parameter int LEVELS = otqd_pkg::LEVELS_DEF
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_start,
    input  wire logic [otqd_pkg::CMD_W-1:0]                 i_cmd,
    input  wire logic [otqd_pkg::MSG_W-1:0]                 i_msg_data,
    input  wire logic                                       i_expecting_feedback,
    input  wire logic                                       i_cfg_we,
    input  wire logic [otqd_pkg::CFG_IDX_W-1:0]             i_cfg_idx,
    input  wire logic [otqd_pkg::CFG_W-1:0]                 i_cfg_wdata,
    input  wire logic                                       i_q_full,
    output logic                                            o_busy,
    output logic                                            o_push,
    output otqd_pkg::t_cmd_ctl                              o_push_ctl,
    output logic [otqd_pkg::MSG_W-1:0]                      o_push_data,
    output logic                                            o_enabled,
    output logic [LEVELS-1:0][otqd_pkg::LIMIT_W-1:0]        o_limit
);

    localparam int LW     = otqd_pkg::LIMIT_W;
    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int DVD_W  = otqd_pkg::LIMIT_W + otqd_pkg::FRAC_BITS;
    localparam int STEP_W = $clog2(DVD_W);

    typedef enum logic [1:0] {
        L_IDLE = 2'b01,
        L_DIV  = 2'b10
    } t_lstate;

    logic                          r_enabled;
    logic [LW-1:0]                 r_base;
    logic [LW-1:0]                 r_decay;
    logic                          r_go;
    logic                          n_go;
    t_lstate                       r_lst;
    t_lstate                       n_lst;
    logic [LVL_W-1:0]              r_lvl;
    logic [STEP_W-1:0]             r_step;
    logic [DVD_W-1:0]              r_dvd;
    logic [LW-1:0]                 r_rem;
    logic [DVD_W-1:0]              r_quo;
    logic [LEVELS-1:0][LW-1:0]     r_limit;

    logic                          accept;
    logic                          cmd_known;
    logic                          cfg_lim_wr;
    logic [LW:0]                   rem_shift;
    logic                          ge;
    logic [LW-1:0]                 n_rem;
    logic [DVD_W-1:0]              n_quo;
    logic [LW-1:0]                 lim_val;
    logic                          step_last;
    logic                          lvl_last;

    // Accept and classify items; unused codes are taken and dropped
    assign o_busy    = r_go || (r_lst == L_DIV) || i_q_full;
    assign accept    = i_start && !o_busy;
    assign cmd_known = (i_cmd == otqd_pkg::OP_ENQ) || (i_cmd == otqd_pkg::OP_POLL) ||
                       (i_cmd == otqd_pkg::OP_CLEAR);
    assign o_push              = accept && cmd_known;
    assign o_push_ctl.op        = otqd_pkg::t_op'(i_cmd);
    assign o_push_ctl.expecting = i_expecting_feedback;
    assign o_push_data          = i_msg_data;

    assign o_enabled = r_enabled;
    assign o_limit   = r_limit;

    // Restoring divider step: one quotient bit per cycle
    assign rem_shift = {r_rem, r_dvd[DVD_W-1]};
    assign ge        = rem_shift >= {1'b0, r_decay};
    assign n_rem     = ge ? LW'(rem_shift - {1'b0, r_decay}) : rem_shift[LW-1:0];
    assign n_quo     = {r_quo[DVD_W-2:0], ge};
    assign lim_val   = (|n_quo[DVD_W-1:LW]) ? {LW{1'b1}} : n_quo[LW-1:0];
    assign step_last = (r_step == STEP_W'(DVD_W - 1));
    assign lvl_last  = (r_lvl == LVL_W'(LEVELS - 1));

    assign cfg_lim_wr = i_cfg_we &&
                        ((i_cfg_idx == otqd_pkg::REG_BASE) || (i_cfg_idx == otqd_pkg::REG_DECAY));

    // Sequence the limit table: restart on any threshold write
    always_comb begin
        n_go  = r_go;
        n_lst = r_lst;
        if (r_go) begin
            n_go = 1'b0;
            if (LEVELS > 1) begin
                n_lst = L_DIV;
            end else begin
                n_lst = L_IDLE;
            end
        end else if ((r_lst == L_DIV) && step_last && lvl_last) begin
            n_lst = L_IDLE;
        end
        if (cfg_lim_wr) begin
            n_go = 1'b1;
        end
    end

    // Hold configuration and sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_base    <= otqd_pkg::BASE_RST;
            r_decay   <= otqd_pkg::DECAY_RST;
            r_go      <= 1'b1;
            r_lst     <= L_IDLE;
        end else begin
            r_go  <= n_go;
            r_lst <= n_lst;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    otqd_pkg::REG_ENABLED: r_enabled <= i_cfg_wdata[0];
                    otqd_pkg::REG_BASE:    r_base    <= i_cfg_wdata;
                    otqd_pkg::REG_DECAY:   r_decay   <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Advance the divider and store each level limit
    always_ff @(posedge i_clk) begin
        if (r_go) begin
            r_limit[0] <= r_base;
            r_lvl      <= LVL_W'(1);
            r_step     <= '0;
            r_dvd      <= {r_base, {otqd_pkg::FRAC_BITS{1'b0}}};
            r_rem      <= '0;
            r_quo      <= '0;
        end else if (r_lst == L_DIV) begin
            r_dvd  <= r_dvd << 1;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_step <= r_step + STEP_W'(1);
            if (step_last) begin
                r_limit[r_lvl] <= lim_val;
                r_lvl          <= r_lvl + LVL_W'(1);
                r_step         <= '0;
                r_dvd          <= {lim_val, {otqd_pkg::FRAC_BITS{1'b0}}};
                r_rem          <= '0;
                r_quo          <= '0;
            end
        end
    end

    // Level 0 follows the base whenever the table is settled
    a_lim0_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |-> (r_limit[0] == r_base))
        else $error("level 0 limit differs from base while settled");

endmodule

`default_nettype wire

### sv/otqd_cmdq.sv
`default_nettype none

module otqd_cmdq #(
    parameter int W     = 1,
    parameter int DEPTH = otqd_pkg::CQ_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_wdata,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_rdata,
    output logic              o_valid,
    output logic              o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_ent [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_rdata = r_ent[r_rp];
    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CW'(DEPTH));

    // Track fill level
    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
        end
    end

    // Hold queued items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_wdata;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command queue written while full");

endmodule

`default_nettype wire

### sv/otqd_back.sv
`default_nettype none

module otqd_back #(
    parameter int FIFO_DEPTH = otqd_pkg::FIFO_DEPTH_DEF,
    parameter int LEVELS     = otqd_pkg::LEVELS_DEF,
    parameter int DATA_WIDTH = otqd_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_q_valid,
    input  wire otqd_pkg::t_cmd_ctl                     i_q_ctl,
    input  wire logic [otqd_pkg::MSG_W-1:0]             i_q_data,
    output logic                                        o_q_pop,
    input  wire logic                                   i_enabled,
    input  wire logic [LEVELS-1:0][otqd_pkg::LIMIT_W-1:0] i_limit,
    output logic                                        o_result_strobe,
    output logic                                        o_msg_valid,
    output logic [otqd_pkg::MSG_W-1:0]                  o_msg_out,
    output logic                                        o_head_dropped,
    output logic                                        o_gap,
    output logic                                        o_last,
    output logic [otqd_pkg::QLEN_W-1:0]                 o_queue_length,
    output logic [otqd_pkg::TOTAL_W-1:0]                o_drop_total,
    output logic [otqd_pkg::TOTAL_W-1:0]                o_gap_total,
    output logic [otqd_pkg::TOTAL_W-1:0]                o_dispatch_total
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int AW    = otqd_pkg::LIMIT_W;
    localparam int TW    = otqd_pkg::TOTAL_W;
    localparam int MW    = otqd_pkg::MSG_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_DRAIN = 3'b100
    } t_bstate;

    // Message store
    logic [DATA_WIDTH-1:0]     mem [FIFO_DEPTH];
    logic [DATA_WIDTH-1:0]     r_rd_data;
    logic                      wr_en;
    logic                      rd_en;
    logic [PTR_W-1:0]          rd_addr;

    // Control state
    t_bstate                   r_state,  n_state;
    logic [PTR_W-1:0]          r_head,   n_head;
    logic [PTR_W-1:0]          r_tail,   n_tail;
    logic [CNT_W-1:0]          r_occ,    n_occ;
    logic [LEVELS-1:0][AW-1:0] r_age,    n_age;
    logic [TW-1:0]             r_drops,  n_drops;
    logic [TW-1:0]             r_gaps,   n_gaps;
    logic [TW-1:0]             r_disp,   n_disp;
    logic                      r_pend,   n_pend;
    logic                      r_o_stb,  n_o_stb;

    // Per-poll payload
    logic                      r_disc,      n_disc;
    logic                      r_exp,       n_exp;
    logic                      r_all,       n_all;
    logic [CNT_W-1:0]          r_pend_len,  n_pend_len;
    logic                      r_pend_last, n_pend_last;
    logic                      r_pend_drop, n_pend_drop;
    logic                      r_o_valid,   n_o_valid;
    logic [MW-1:0]             r_o_data,    n_o_data;
    logic                      r_o_drop,    n_o_drop;
    logic                      r_o_gap,     n_o_gap;
    logic                      r_o_last,    n_o_last;
    logic [CNT_W-1:0]          r_o_len,     n_o_len;

    logic [LEVELS-1:0][AW-1:0] age_upd;
    logic                      disc_any;
    logic [PTR_W-1:0]          h1;
    logic [CNT_W-1:0]          o1;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TW] ? {TW{1'b1}} : s[TW-1:0];
    endfunction

    // Age each backlog level and look for a level over its limit
    always_comb begin
        disc_any = 1'b0;
        for (int i = 0; i < LEVELS; i++) begin
            if ((i + 2) < int'(r_occ)) begin
                age_upd[i] = (r_age[i] == {AW{1'b1}}) ? r_age[i] : r_age[i] + AW'(1);
            end else begin
                age_upd[i] = '0;
            end
            if (age_upd[i] > i_limit[i]) begin
                disc_any = 1'b1;
            end
        end
    end

    // Head after an optional discard, as seen in the check step
    assign h1 = r_disc ? ptr_inc(r_head) : r_head;
    assign o1 = r_occ - CNT_W'(r_disc);

    // Execute commands and emit results
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_occ       = r_occ;
        n_age       = r_age;
        n_drops     = r_drops;
        n_gaps      = r_gaps;
        n_disp      = r_disp;
        n_pend      = r_pend;
        n_o_stb     = 1'b0;
        n_disc      = r_disc;
        n_exp       = r_exp;
        n_all       = r_all;
        n_pend_len  = r_pend_len;
        n_pend_last = r_pend_last;
        n_pend_drop = r_pend_drop;
        n_o_valid   = r_o_valid;
        n_o_data    = r_o_data;
        n_o_drop    = r_o_drop;
        n_o_gap     = r_o_gap;
        n_o_last    = r_o_last;
        n_o_len     = r_o_len;
        o_q_pop     = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_head;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    case (i_q_ctl.op)
                        otqd_pkg::OP_ENQ: begin
                            if (r_occ == CNT_W'(FIFO_DEPTH)) begin
                                n_drops = sat_add(r_drops, TW'(1));
                            end else begin
                                wr_en  = 1'b1;
                                n_tail = ptr_inc(r_tail);
                                n_occ  = r_occ + CNT_W'(1);
                            end
                        end
                        otqd_pkg::OP_CLEAR: begin
                            n_drops = '0;
                            n_gaps  = '0;
                        end
                        otqd_pkg::OP_POLL: begin
                            n_exp = i_q_ctl.expecting;
                            if (!i_enabled) begin
                                if (r_occ == '0) begin
                                    // Report an empty poll straight away
                                    n_o_stb   = 1'b1;
                                    n_o_valid = 1'b0;
                                    n_o_data  = '0;
                                    n_o_drop  = 1'b0;
                                    n_o_gap   = 1'b1;
                                    n_o_last  = 1'b1;
                                    n_o_len   = '0;
                                    if (i_q_ctl.expecting) begin
                                        n_gaps = sat_add(r_gaps, TW'(1));
                                    end
                                end else begin
                                    // Drain: all but the last entry count as drops
                                    n_drops = sat_add(r_drops, TW'(r_occ - CNT_W'(1)));
                                    n_all   = 1'b1;
                                    n_pend  = 1'b0;
                                    n_state = S_DRAIN;
                                end
                            end else begin
                                n_disc = disc_any;
                                if (disc_any) begin
                                    n_drops = sat_add(r_drops, TW'(1));
                                    n_age   = '0;
                                end else begin
                                    n_age   = age_upd;
                                end
                                n_state = S_CHECK;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_CHECK: begin
                n_head = h1;
                n_occ  = o1;
                if (o1 == '0) begin
                    n_o_stb   = 1'b1;
                    n_o_valid = 1'b0;
                    n_o_data  = '0;
                    n_o_drop  = r_disc;
                    n_o_gap   = 1'b1;
                    n_o_last  = 1'b1;
                    n_o_len   = '0;
                    if (r_exp) begin
                        n_gaps = sat_add(r_gaps, TW'(1));
                    end
                    n_state = S_IDLE;
                end else begin
                    // Read the new head and hand it to the emit step
                    rd_en       = 1'b1;
                    rd_addr     = h1;
                    n_head      = ptr_inc(h1);
                    n_occ       = o1 - CNT_W'(1);
                    n_pend      = 1'b1;
                    n_pend_len  = o1 - CNT_W'(1);
                    n_pend_last = 1'b1;
                    n_pend_drop = r_disc;
                    n_all       = 1'b0;
                    n_state     = S_DRAIN;
                end
            end

            S_DRAIN: begin
                // Emit the entry read last cycle
                if (r_pend) begin
                    n_o_stb   = 1'b1;
                    n_o_valid = 1'b1;
                    n_o_data  = MW'(r_rd_data);
                    n_o_drop  = r_pend_drop;
                    n_o_gap   = 1'b0;
                    n_o_last  = r_pend_last;
                    n_o_len   = r_pend_len;
                    n_disp    = sat_add(r_disp, TW'(1));
                end
                // Read the next entry in the same cycle
                if (r_all && (r_occ != '0)) begin
                    rd_en       = 1'b1;
                    rd_addr     = r_head;
                    n_head      = ptr_inc(r_head);
                    n_occ       = r_occ - CNT_W'(1);
                    n_pend      = 1'b1;
                    n_pend_len  = r_occ - CNT_W'(1);
                    n_pend_last = (r_occ == CNT_W'(1));
                    n_pend_drop = 1'b0;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_occ   <= '0;
            r_age   <= '0;
            r_drops <= '0;
            r_gaps  <= '0;
            r_disp  <= '0;
            r_pend  <= 1'b0;
            r_o_stb <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_occ   <= n_occ;
            r_age   <= n_age;
            r_drops <= n_drops;
            r_gaps  <= n_gaps;
            r_disp  <= n_disp;
            r_pend  <= n_pend;
            r_o_stb <= n_o_stb;
        end
    end

    // Hold poll payload and the result register
    always_ff @(posedge i_clk) begin
        r_disc      <= n_disc;
        r_exp       <= n_exp;
        r_all       <= n_all;
        r_pend_len  <= n_pend_len;
        r_pend_last <= n_pend_last;
        r_pend_drop <= n_pend_drop;
        r_o_valid   <= n_o_valid;
        r_o_data    <= n_o_data;
        r_o_drop    <= n_o_drop;
        r_o_gap     <= n_o_gap;
        r_o_last    <= n_o_last;
        r_o_len     <= n_o_len;
    end

    // Message store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_tail] <= DATA_WIDTH'(i_q_data);
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_result_strobe  = r_o_stb;
    assign o_msg_valid      = r_o_valid;
    assign o_msg_out        = r_o_data;
    assign o_head_dropped   = r_o_drop;
    assign o_gap            = r_o_gap;
    assign o_last           = r_o_last;
    assign o_queue_length   = otqd_pkg::QLEN_W'(r_o_len);
    assign o_drop_total     = r_drops;
    assign o_gap_total      = r_gaps;
    assign o_dispatch_total = r_disp;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(FIFO_DEPTH))
        else $error("occupancy beyond store depth");

    a_more_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_stb && !r_o_last) |-> (r_state == S_DRAIN))
        else $error("non-final result outside a drain");

    a_gap_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_stb && r_o_gap) |-> (!r_o_valid && r_o_last && (r_o_len == '0)))
        else $error("gap result carries a message or a backlog");

endmodule

`default_nettype wire

### sv/occupancy_threshold_queue_dropper_core.sv
`default_nettype none

// Channel     Ports                                          Handshake
// ---------   --------------------------------------------   -------------------------------
// command     i_cmd, i_msg_data, i_expecting_feedback         taken when start && !busy
// result      o_msg_valid .. o_dispatch_total                 one cycle, o_result_strobe high
// config      i_cfg_idx, i_cfg_wdata                          written when i_cfg_we is high
//
// Enqueue and clear are done in the back-end idle state; an enabled poll passes dequeue and
// age check, head read (skipped when the backlog empties) and the result register after it
// leaves the command queue. A disabled poll drains one entry per cycle after a set-up step.
// A two-entry command queue parts the front from the back; busy rises when it is full.
// After reset and after a write to base_threshold or decay_q8 the level limits are rebuilt by
// a bit-serial divider, with busy high until it is done. The receiver cannot stall.

module occupancy_threshold_queue_dropper_core #(
    parameter int FIFO_DEPTH = otqd_pkg::FIFO_DEPTH_DEF,
    parameter int LEVELS     = otqd_pkg::LEVELS_DEF,
    parameter int DATA_WIDTH = otqd_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [otqd_pkg::CMD_W-1:0]         i_cmd,
    input  wire logic [otqd_pkg::MSG_W-1:0]         i_msg_data,
    input  wire logic                               i_expecting_feedback,
    input  wire logic                               i_cfg_we,
    input  wire logic [otqd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [otqd_pkg::CFG_W-1:0]         i_cfg_wdata,
    output logic                                    o_result_strobe,
    output logic                                    o_msg_valid,
    output logic [otqd_pkg::MSG_W-1:0]              o_msg_out,
    output logic                                    o_head_dropped,
    output logic                                    o_gap,
    output logic                                    o_last,
    output logic [otqd_pkg::QLEN_W-1:0]             o_queue_length,
    output logic [otqd_pkg::TOTAL_W-1:0]            o_drop_total,
    output logic [otqd_pkg::TOTAL_W-1:0]            o_gap_total,
    output logic [otqd_pkg::TOTAL_W-1:0]            o_dispatch_total
);

    localparam int MW = otqd_pkg::MSG_W;
    localparam int QW = $bits(otqd_pkg::t_cmd_ctl) + MW;

    logic                                       q_full;
    logic                                       push;
    otqd_pkg::t_cmd_ctl                         push_ctl;
    logic [MW-1:0]                              push_data;
    logic [QW-1:0]                              q_wdata;
    logic [QW-1:0]                              q_rdata;
    logic                                       q_valid;
    logic                                       q_pop;
    otqd_pkg::t_cmd_ctl                         q_ctl;
    logic                                       enabled;
    logic [LEVELS-1:0][otqd_pkg::LIMIT_W-1:0]   limit;

    otqd_front #(
        .LEVELS (LEVELS)
    ) u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_start              (start),
        .i_cmd                (i_cmd),
        .i_msg_data           (i_msg_data),
        .i_expecting_feedback (i_expecting_feedback),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_q_full             (q_full),
        .o_busy               (busy),
        .o_push               (push),
        .o_push_ctl           (push_ctl),
        .o_push_data          (push_data),
        .o_enabled            (enabled),
        .o_limit              (limit)
    );

    // Pack classified commands for the queue
    assign q_wdata = {push_ctl, push_data};
    assign q_ctl   = otqd_pkg::t_cmd_ctl'(q_rdata[QW-1:MW]);

    otqd_cmdq #(
        .W     (QW),
        .DEPTH (otqd_pkg::CQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    otqd_back #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .LEVELS     (LEVELS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_ctl          (q_ctl),
        .i_q_data         (q_rdata[MW-1:0]),
        .o_q_pop          (q_pop),
        .i_enabled        (enabled),
        .i_limit          (limit),
        .o_result_strobe  (o_result_strobe),
        .o_msg_valid      (o_msg_valid),
        .o_msg_out        (o_msg_out),
        .o_head_dropped   (o_head_dropped),
        .o_gap            (o_gap),
        .o_last           (o_last),
        .o_queue_length   (o_queue_length),
        .o_drop_total     (o_drop_total),
        .o_gap_total      (o_gap_total),
        .o_dispatch_total (o_dispatch_total)
    );

endmodule

`default_nettype wire

### sim/tb_occupancy_threshold_queue_dropper_core.sv
`timescale 1ns / 100ps

module tb_occupancy_threshold_queue_dropper_core;

    localparam int DEPTH         = otqd_pkg::FIFO_DEPTH_DEF;
    localparam int NLEVELS       = otqd_pkg::LEVELS_DEF;
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 4000;

    // Command code with no operation behind it
    localparam logic [otqd_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic                         valid;
        logic [otqd_pkg::MSG_W-1:0]   data;
        logic                         dropped;
        logic                         gap;
        logic                         last;
        logic [otqd_pkg::QLEN_W-1:0]  qlen;
        logic [otqd_pkg::TOTAL_W-1:0] drops;
        logic [otqd_pkg::TOTAL_W-1:0] gaps;
        logic [otqd_pkg::TOTAL_W-1:0] dispatches;
    } t_poll_result;

    typedef struct packed {
        logic [otqd_pkg::CMD_W-1:0] cmd;
        logic [otqd_pkg::MSG_W-1:0] data;
        logic                       fb;
        logic [4:0]                 reps;
        logic                       typed;
        t_poll_result               res;
    } t_stim_row;

    localparam t_poll_result NO_RES = '0;
    localparam int ROWS = 13;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             start;
    logic                             busy;
    logic [otqd_pkg::CMD_W-1:0]       i_cmd;
    logic [otqd_pkg::MSG_W-1:0]       i_msg_data;
    logic                             i_expecting_feedback;
    logic                             i_cfg_we;
    logic [otqd_pkg::CFG_IDX_W-1:0]   i_cfg_idx;
    logic [otqd_pkg::CFG_W-1:0]       i_cfg_wdata;
    logic                             o_result_strobe;
    logic                             o_msg_valid;
    logic [otqd_pkg::MSG_W-1:0]       o_msg_out;
    logic                             o_head_dropped;
    logic                             o_gap;
    logic                             o_last;
    logic [otqd_pkg::QLEN_W-1:0]      o_queue_length;
    logic [otqd_pkg::TOTAL_W-1:0]     o_drop_total;
    logic [otqd_pkg::TOTAL_W-1:0]     o_gap_total;
    logic [otqd_pkg::TOTAL_W-1:0]     o_dispatch_total;

    occupancy_threshold_queue_dropper_core u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_cmd                (i_cmd),
        .i_msg_data           (i_msg_data),
        .i_expecting_feedback (i_expecting_feedback),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_wdata          (i_cfg_wdata),
        .o_result_strobe      (o_result_strobe),
        .o_msg_valid          (o_msg_valid),
        .o_msg_out            (o_msg_out),
        .o_head_dropped       (o_head_dropped),
        .o_gap                (o_gap),
        .o_last               (o_last),
        .o_queue_length       (o_queue_length),
        .o_drop_total         (o_drop_total),
        .o_gap_total          (o_gap_total),
        .o_dispatch_total     (o_dispatch_total)
    );

    // Directed items; typed results only where they are obvious
    t_stim_row plan [0:ROWS-1] = '{
        // empty poll straight after reset, feedback expected
        '{otqd_pkg::OP_POLL, 32'h0, 1'b1, 5'd1, 1'b1,
          '{1'b0, 32'h0, 1'b0, 1'b1, 1'b1, 5'd0, 32'd0, 32'd1, 32'd0}},
        // empty poll without feedback leaves the gap count alone
        '{otqd_pkg::OP_POLL, 32'h0, 1'b0, 5'd1, 1'b1,
          '{1'b0, 32'h0, 1'b0, 1'b1, 1'b1, 5'd0, 32'd0, 32'd1, 32'd0}},
        '{CMD_SPARE, 32'hFFFF_FFFF, 1'b1, 5'd1, 1'b0, NO_RES},
        '{otqd_pkg::OP_ENQ, 32'hFFFF_FFFF, 1'b0, 5'd1, 1'b0, NO_RES},
        '{otqd_pkg::OP_ENQ, 32'h0000_0000, 1'b1, 5'd1, 1'b0, NO_RES},
        '{otqd_pkg::OP_ENQ, 32'h8000_0001, 1'b0, 5'd1, 1'b0, NO_RES},
        // disabled poll drains all three
        '{otqd_pkg::OP_POLL, 32'h5A5A_A5A5, 1'b1, 5'd1, 1'b0, NO_RES},
        '{otqd_pkg::OP_CLEAR, 32'h0, 1'b0, 5'd1, 1'b0, NO_RES},
        '{otqd_pkg::OP_POLL, 32'h0, 1'b1, 5'd1, 1'b1,
          '{1'b0, 32'h0, 1'b0, 1'b1, 1'b1, 5'd0, 32'd0, 32'd1, 32'd3}},
        // overfill: the seventeenth enqueue is dropped
        '{otqd_pkg::OP_ENQ, 32'h1234_5678, 1'b0, 5'd17, 1'b0, NO_RES},
        '{otqd_pkg::OP_POLL, 32'h0, 1'b0, 5'd1, 1'b0, NO_RES},
        '{otqd_pkg::OP_CLEAR, 32'hFFFF_FFFF, 1'b1, 5'd1, 1'b0, NO_RES},
        '{otqd_pkg::OP_POLL, 32'h0, 1'b0, 5'd1, 1'b1,
          '{1'b0, 32'h0, 1'b0, 1'b1, 1'b1, 5'd0, 32'd0, 32'd0, 32'd19}}
    };

    // Queue and statistics as the block should hold them
    logic [otqd_pkg::MSG_W-1:0]   q_store [DEPTH];
    int                           q_head;
    int                           q_tail;
    int                           q_occ;
    logic [otqd_pkg::LIMIT_W-1:0] lvl_age [NLEVELS];
    logic [otqd_pkg::LIMIT_W-1:0] lvl_limit [NLEVELS];
    logic [otqd_pkg::TOTAL_W-1:0] drop_cnt;
    logic [otqd_pkg::TOTAL_W-1:0] gap_cnt;
    logic [otqd_pkg::TOTAL_W-1:0] dispatch_cnt;
    logic                         mode_en;
    logic [otqd_pkg::LIMIT_W-1:0] base_cfg;
    logic [otqd_pkg::LIMIT_W-1:0] decay_cfg;

    t_poll_result due_results [$];
    int           mismatches = 0;
    int           stall_cycles = 0;
    bit           quiet;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [otqd_pkg::TOTAL_W-1:0] sat_add(
        logic [otqd_pkg::TOTAL_W-1:0] a, logic [otqd_pkg::TOTAL_W-1:0] b);
        logic [otqd_pkg::TOTAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[otqd_pkg::TOTAL_W] ? '1 : s[otqd_pkg::TOTAL_W-1:0];
    endfunction

    // Rebuild the per-level limits: divide by decay in 8.8, truncate, saturate
    function automatic void rebuild_limits();
        logic [31:0] t;
        t = {16'd0, base_cfg};
        for (int i = 0; i < NLEVELS; i++) begin
            lvl_limit[i] = t[otqd_pkg::LIMIT_W-1:0];
            if (decay_cfg == '0) begin
                t = 32'd65535;
            end else begin
                t = (t << otqd_pkg::FRAC_BITS) / decay_cfg;
                if (t > 32'd65535) t = 32'd65535;
            end
        end
    endfunction

    function automatic void reset_model();
        q_head       = 0;
        q_tail       = 0;
        q_occ        = 0;
        drop_cnt     = '0;
        gap_cnt      = '0;
        dispatch_cnt = '0;
        mode_en      = 1'b0;
        base_cfg     = otqd_pkg::BASE_RST;
        decay_cfg    = otqd_pkg::DECAY_RST;
        foreach (lvl_age[i]) lvl_age[i] = '0;
        foreach (q_store[i]) q_store[i] = '0;
        rebuild_limits();
    endfunction

    function automatic void post_result(logic valid, logic [otqd_pkg::MSG_W-1:0] data,
                                        logic dropped, logic gap, logic last);
        t_poll_result r;
        r.valid      = valid;
        r.data       = valid ? data : '0;
        r.dropped    = dropped;
        r.gap        = gap;
        r.last       = last;
        r.qlen       = otqd_pkg::QLEN_W'(q_occ);
        r.drops      = drop_cnt;
        r.gaps       = gap_cnt;
        r.dispatches = dispatch_cnt;
        due_results.push_back(r);
    endfunction

    function automatic logic [otqd_pkg::MSG_W-1:0] pop_head();
        logic [otqd_pkg::MSG_W-1:0] v;
        v      = q_store[q_head];
        q_head = (q_head + 1) % DEPTH;
        q_occ--;
        return v;
    endfunction

    // Dispatch the head, or report an empty poll
    function automatic void dispatch_head(logic dropped, logic last_anyway, logic fb);
        logic [otqd_pkg::MSG_W-1:0] v;
        if (q_occ == 0) begin
            if (fb) gap_cnt = sat_add(gap_cnt, 1);
            post_result(1'b0, '0, dropped, 1'b1, 1'b1);
        end else begin
            v            = pop_head();
            dispatch_cnt = sat_add(dispatch_cnt, 1);
            post_result(1'b1, v, dropped, 1'b0, last_anyway || q_occ == 0);
        end
    endfunction

    // Work out the results of one accepted item
    function automatic void predict_item(logic [otqd_pkg::CMD_W-1:0] cmd,
                                         logic [otqd_pkg::MSG_W-1:0] data, logic fb);
        logic discard;
        int   n;
        case (cmd)
            otqd_pkg::OP_ENQ: begin
                if (q_occ >= DEPTH) begin
                    drop_cnt = sat_add(drop_cnt, 1);
                end else begin
                    q_store[q_tail] = data;
                    q_tail          = (q_tail + 1) % DEPTH;
                    q_occ++;
                end
            end
            otqd_pkg::OP_CLEAR: begin
                drop_cnt = '0;
                gap_cnt  = '0;
            end
            otqd_pkg::OP_POLL: begin
                if (!mode_en) begin
                    // drain everything; all but the last count as drops
                    if (q_occ > 0) begin
                        drop_cnt = sat_add(drop_cnt, otqd_pkg::TOTAL_W'(q_occ - 1));
                    end
                    n = 0;
                    do begin
                        dispatch_head(1'b0, 1'b0, fb);
                        n++;
                    end while (q_occ > 0 && n < DEPTH);
                end else begin
                    // age the deep levels, clear the rest
                    discard = 1'b0;
                    for (int i = 0; i < NLEVELS; i++) begin
                        if (q_occ >= 2 && i < q_occ - 2) begin
                            if (lvl_age[i] != '1) lvl_age[i]++;
                        end else begin
                            lvl_age[i] = '0;
                        end
                        if (lvl_age[i] > lvl_limit[i]) discard = 1'b1;
                    end
                    if (discard) begin
                        drop_cnt = sat_add(drop_cnt, 1);
                        if (q_occ > 0) void'(pop_head());
                        foreach (lvl_age[i]) lvl_age[i] = '0;
                    end
                    dispatch_head(discard, 1'b1, fb);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [otqd_pkg::MSG_W-1:0] pick_data();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Present one item and hold it until the block takes it
    task automatic send_item(input logic [otqd_pkg::CMD_W-1:0] cmd,
                             input logic [otqd_pkg::MSG_W-1:0] data, input logic fb);
        int pause;
        pause = pick_gap();
        if (pause > 0) begin
            start <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
        start                <= 1'b1;
        i_cmd                <= cmd;
        i_msg_data           <= data;
        i_expecting_feedback <= fb;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_item(cmd, data, fb);
    endtask

    // Write a register once the block has gone quiet
    task automatic write_reg(input logic [otqd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [otqd_pkg::CFG_W-1:0] value);
        start <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            otqd_pkg::REG_ENABLED: mode_en = value[0];
            otqd_pkg::REG_BASE: begin
                base_cfg = value;
                rebuild_limits();
            end
            otqd_pkg::REG_DECAY: begin
                decay_cfg = value;
                rebuild_limits();
            end
            default: ;
        endcase
    endtask

    // Fill a little, poll a little, with the odd clear or spare code in between
    task automatic run_phase(input logic en, input logic [otqd_pkg::CFG_W-1:0] base,
                             input logic [otqd_pkg::CFG_W-1:0] decay, input int items);
        int sent;
        int fills;
        int polls;
        write_reg(otqd_pkg::REG_ENABLED, {15'd0, en});
        write_reg(otqd_pkg::REG_BASE, base);
        write_reg(otqd_pkg::REG_DECAY, decay);
        sent = 0;
        while (sent < items) begin
            quiet = ($urandom_range(0, 7) == 0);
            fills = $urandom_range(0, 8);
            polls = $urandom_range(1, 6);
            repeat (fills) begin
                send_item(otqd_pkg::OP_ENQ, pick_data(), 1'($urandom_range(0, 1)));
                sent++;
            end
            repeat (polls) begin
                send_item(otqd_pkg::OP_POLL, pick_data(), 1'($urandom_range(0, 1)));
                sent++;
            end
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1) == 1) begin
                    send_item(otqd_pkg::OP_CLEAR, pick_data(), 1'($urandom_range(0, 1)));
                    sent++;
                end else begin
                    send_item(CMD_SPARE, pick_data(), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Compare every strobed result with the oldest expectation
    always @(posedge i_clk) begin
        t_poll_result want;
        if (i_rst_n === 1'b1 && o_result_strobe === 1'b1) begin
            if (due_results.size() == 0) begin
                $display("%0t: result with nothing expected, msg_out %h", $time, o_msg_out);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                check_field("msg_valid", 32'(want.valid), 32'(o_msg_valid));
                check_field("msg_out", want.data, o_msg_out);
                check_field("head_dropped", 32'(want.dropped), 32'(o_head_dropped));
                check_field("gap", 32'(want.gap), 32'(o_gap));
                check_field("last", 32'(want.last), 32'(o_last));
                check_field("queue_length", 32'(want.qlen), 32'(o_queue_length));
                check_field("drop_total", want.drops, o_drop_total);
                check_field("gap_total", want.gaps, o_gap_total);
                check_field("dispatch_total", want.dispatches, o_dispatch_total);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) ||
            o_result_strobe === 1'b1 || i_cfg_we === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_occupancy_threshold_queue_dropper_core: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n              <= 1'b0;
        start                <= 1'b0;
        i_cmd                <= otqd_pkg::OP_ENQ;
        i_msg_data           <= '0;
        i_expecting_feedback <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= otqd_pkg::REG_ENABLED;
        i_cfg_wdata          <= '0;
        quiet = 1'b0;
        reset_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under reset settings
        foreach (plan[r]) begin
            for (int k = 0; k < plan[r].reps; k++) begin
                send_item(plan[r].cmd, plan[r].data + k, plan[r].fb);
                if (plan[r].typed) begin
                    void'(due_results.pop_back());
                    due_results.push_back(plan[r].res);
                end
            end
        end

        // Random items across settings, extremes included
        run_phase(1'b1, 16'd150, 16'd512, 70);
        run_phase(1'b1, 16'd0, 16'd1, 60);
        run_phase(1'b1, 16'd3, 16'd256, 60);
        run_phase(1'b0, 16'd10, 16'd1, 50);
        run_phase(1'b1, 16'd2, 16'd128, 70);
        run_phase(1'b1, 16'hFFFF, 16'hFFFF, 60);
        run_phase(1'b1, 16'd5, 16'd0, 60);
        run_phase(1'b1, 16'($urandom_range(0, 20)), 16'($urandom_range(1, 1024)), 70);

        // Let the last results out, then a little longer for strays
        start <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_occupancy_threshold_queue_dropper_core: clean");
        end else begin
            $display("tb_occupancy_threshold_queue_dropper_core: errors");
        end
        $finish;
    end

endmodule

### occupancy_threshold_queue_dropper_core.f
sv/otqd_pkg.sv
sv/otqd_front.sv
sv/otqd_cmdq.sv
sv/otqd_back.sv
sv/occupancy_threshold_queue_dropper_core.sv
sim/tb_occupancy_threshold_queue_dropper_core.sv
